// File: design/fsf_pkg.sv
// shared types, constants and sector helpers for the fiducial sector filter
package fsf_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ROW    = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_SECT_EN    = 3'd0,
    CFG_SECT_SEL   = 3'd1,
    CFG_CALO_MIN   = 3'd2,
    CFG_CALO_MAX   = 3'd3,
    CFG_CHAMB_MIN  = 3'd4,
    CFG_CHAMB_MAX  = 3'd5,
    CFG_SPARE_6    = 3'd6,
    CFG_SPARE_7    = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    EM_IDLE = 1'b0,
    EM_WALK = 1'b1
  } emit_state_t;

  localparam logic [7:0] DET_CALO        = 8'd7;
  localparam logic [7:0] DET_CHAMBER     = 8'd6;
  localparam logic [7:0] LAYER_PRESHOWER = 8'd1;

  typedef struct packed {
    op_t                operation;
    logic [6:0]         particle_count;
    logic [5:0]         particle_index;
    logic [7:0]         detector_id;
    logic [7:0]         layer_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] edge_dist;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_index;
    logic       pass_flag;
    logic       last_flag;
  } out_item_t;

  typedef struct packed {
    logic               sect_en;
    logic [2:0]         sect_sel;
    logic signed [15:0] calo_min;
    logic signed [15:0] calo_max;
    logic signed [15:0] chamb_min;
    logic signed [15:0] chamb_max;
  } cfg_t;

  // flag update leaving the row check stage
  typedef struct packed {
    logic       valid;
    logic [5:0] idx;
    logic       reject;
  } row_upd_t;

  // emit walker tag, aligned with the memory read data
  typedef struct packed {
    logic       valid;
    logic [5:0] index;
    logic       last;
  } emit_tag_t;

  // sign of s*sqrt(3) + t; big means 3*s*s > t*t
  function automatic logic signed [1:0] sgn_r3(logic signed [1:0] s,
                                                logic signed [1:0] t,
                                                logic big);
    logic signed [1:0] r;
    if (s == 2'sd0) r = t;
    else if (t == 2'sd0) r = s;
    else if (s > 2'sd0 && t > 2'sd0) r = 2'sd1;
    else if (s < 2'sd0 && t < 2'sd0) r = -2'sd1;
    else r = big ? s : t;
    return r;
  endfunction

  // inside the half plane starting at a ray, or on the ray itself
  function automatic logic half(logic signed [1:0] cr_sgn, logic signed [1:0] dot);
    return (cr_sgn > 2'sd0) || (cr_sgn == 2'sd0 && dot > 2'sd0);
  endfunction

  function automatic logic [2:0] sector_of(logic h30, logic h90, logic h150);
    logic [2:0] s;
    unique case ({h30, h90, h150})
      3'b100:  s = 3'd2;
      3'b110:  s = 3'd3;
      3'b111:  s = 3'd4;
      3'b011:  s = 3'd5;
      3'b001:  s = 3'd6;
      default: s = 3'd1;
    endcase
    return s;
  endfunction

endpackage

// File: design/fsf_flag_mem.sv
// pass flag memory with per-entry valid bits and write forwarding
module fsf_flag_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_flag,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data
);

  logic             flag_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic             rd_data_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_addr_r;
  logic             wb_vld_r;
  logic [AW-1:0]    wb_addr_r;
  logic             wb_data_r;

  always_ff @(posedge clk) begin
    if (wr_en && !clear) begin
      flag_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= flag_mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
    rd_addr_r <= rd_addr;
    wb_addr_r <= wr_addr;
    wb_data_r <= wr_data;
  end

  // a start returns every entry to pass at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      wb_vld_r <= 1'b0;
    end else if (clear) begin
      vld_r    <= '0;
      wb_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      wb_vld_r <= wr_en;
    end
  end

  // read and write on the same edge: the read saw old data
  always_comb begin
    if (wb_vld_r && wb_addr_r == rd_addr_r) rd_flag = wb_data_r;
    else if (rd_vld_r)                      rd_flag = rd_data_r;
    else                                    rd_flag = 1'b1;
  end

endmodule

// File: design/fsf_row_check.sv
// trajectory row cuts: edge windows and preshower azimuth sector check
module fsf_row_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              row_go,
  input  fsf_pkg::in_item_t item,
  input  fsf_pkg::cfg_t     cfg,
  output fsf_pkg::row_upd_t upd
);

  logic                v_r;
  logic [5:0]          idx_r;
  logic                edge_bad_r;
  logic                sect_chk_r;
  logic [31:0]         xx_r;
  logic [31:0]         yy_r;
  logic signed [1:0]   sx_r;
  logic signed [1:0]   sy_r;

  logic signed [16:0]  x17;
  logic signed [16:0]  y17;
  logic signed [33:0]  xsq;
  logic signed [33:0]  ysq;
  logic signed [15:0]  e;
  logic                edge_bad;
  logic                gx;
  logic                gy;
  logic                h30;
  logic                h90;
  logic                h150;
  logic [2:0]          sector;

  assign x17 = 17'(item.pos_x);
  assign y17 = 17'(item.pos_y);
  assign xsq = x17 * x17;
  assign ysq = y17 * y17;
  assign e   = item.edge_dist;

  always_comb begin
    edge_bad = 1'b0;
    if (item.detector_id == fsf_pkg::DET_CALO) begin
      edge_bad = (e < cfg.calo_min) || (e > cfg.calo_max);
    end else if (item.detector_id == fsf_pkg::DET_CHAMBER) begin
      edge_bad = (e < cfg.chamb_min) || (e > cfg.chamb_max);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= row_go;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= item.particle_index;
    edge_bad_r <= edge_bad;
    sect_chk_r <= cfg.sect_en && item.detector_id == fsf_pkg::DET_CALO &&
                  item.layer_id == fsf_pkg::LAYER_PRESHOWER;
    xx_r       <= xsq[31:0];
    yy_r       <= ysq[31:0];
    sx_r       <= (item.pos_x > 16'sd0) ? 2'sd1 : ((item.pos_x < 16'sd0) ? -2'sd1 : 2'sd0);
    sy_r       <= (item.pos_y > 16'sd0) ? 2'sd1 : ((item.pos_y < 16'sd0) ? -2'sd1 : 2'sd0);
  end

  // 3y^2 > x^2 and 3x^2 > y^2 decide every sqrt(3) comparison
  assign gy = ({2'b00, yy_r} + {1'b0, yy_r, 1'b0}) > {2'b00, xx_r};
  assign gx = ({2'b00, xx_r} + {1'b0, xx_r, 1'b0}) > {2'b00, yy_r};

  assign h30  = fsf_pkg::half(fsf_pkg::sgn_r3(sy_r, -sx_r, gy),
                              fsf_pkg::sgn_r3(sx_r, sy_r, gx));
  assign h90  = fsf_pkg::half(-sx_r, sy_r);
  assign h150 = fsf_pkg::half(fsf_pkg::sgn_r3(-sy_r, -sx_r, gy),
                              fsf_pkg::sgn_r3(-sx_r, sy_r, gx));
  assign sector = fsf_pkg::sector_of(h30, h90, h150);

  assign upd.valid  = v_r;
  assign upd.idx    = idx_r;
  assign upd.reject = edge_bad_r || (sect_chk_r && sector != cfg.sect_sel);

endmodule

// File: design/fsf_emit.sv
// finish walker: reads one flag per cycle and tags it for the result port
module fsf_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fin_go,
  input  logic [6:0]         event_size,
  output logic               busy,
  output logic [5:0]         rd_idx,
  output fsf_pkg::emit_tag_t tag
);

  fsf_pkg::emit_state_t state_r, state_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  fsf_pkg::emit_tag_t   tag_r, tag_nxt;
  logic                 last;

  assign last = ({1'b0, cnt_r} + 7'd1) == event_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsf_pkg::EM_IDLE;
      cnt_r   <= '0;
      tag_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tag_r   <= tag_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = '0;
    unique case (state_r)
      fsf_pkg::EM_IDLE: begin
        if (fin_go && event_size != 7'd0) begin
          state_nxt = fsf_pkg::EM_WALK;
          cnt_nxt   = '0;
        end
      end
      fsf_pkg::EM_WALK: begin
        tag_nxt.valid = 1'b1;
        tag_nxt.index = cnt_r;
        tag_nxt.last  = last;
        cnt_nxt       = cnt_r + 6'd1;
        if (last) begin
          state_nxt = fsf_pkg::EM_IDLE;
        end
      end
      default: state_nxt = fsf_pkg::EM_IDLE;
    endcase
  end

  assign busy   = state_r == fsf_pkg::EM_WALK;
  assign rd_idx = cnt_r;
  assign tag    = tag_r;

endmodule

// File: design/track_fiducial_sector_filter_top.sv
// top level of the per-event track fiducial and sector filter
//
// Input channel: an item is taken at a clock edge with in_start high and
// in_busy low. A start item opens an event and marks every particle as
// passing. A trajectory row (one item per cycle while in_busy is low) is
// checked in a one-stage pipeline and its particle's flag is read, cleared
// on a failed cut and written back to the flag memory at the edge after the
// transfer; back-to-back rows on one particle are forwarded around the
// memory. A finish item walks the flags, one particle per cycle: results
// appear on out_item with out_valid high for one cycle each, the first once
// the walker state and then the tag register are loaded, and in_busy stays
// high while the walker owns the memory read port, so no next item is taken
// until the walk ends. An empty event gives no results. The result channel
// has no back-pressure: each result is transferred in the cycle it is shown.
// Configuration: cfg_index/cfg_data, written on cfg_valid (cfg_ready is
// always high); the user must write it only while no item is in flight,
// which the block itself does not enforce. Reset (rst_n low, synchronous)
// clears the configuration to its defaults, sets the event size to zero
// and marks all flags as passing at once.
module track_fiducial_sector_filter_top #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_start,
  output logic               in_busy,
  input  fsf_pkg::in_item_t  in_item,
  output logic               out_valid,
  output fsf_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam logic [6:0] EMIT_LIMIT = 7'((MAX_PARTICLES < 64) ? MAX_PARTICLES : 64);

  fsf_pkg::cfg_t      cfg_r;
  logic [6:0]         size_r;
  logic               accept;
  logic               start_go;
  logic               row_go;
  logic               fin_go;
  logic [5:0]         rd_idx;
  logic [AW-1:0]      rd_addr;
  logic               rd_flag;
  fsf_pkg::row_upd_t  upd;
  fsf_pkg::emit_tag_t tag;

  assign accept   = in_start && !in_busy;
  assign start_go = accept && in_item.operation == fsf_pkg::OP_START;
  assign fin_go   = accept && in_item.operation == fsf_pkg::OP_FINISH;
  assign row_go   = accept && in_item.operation == fsf_pkg::OP_ROW &&
                    ({1'b0, in_item.particle_index} < size_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sect_en   <= 1'b0;
      cfg_r.sect_sel  <= 3'd1;
      cfg_r.calo_min  <= -16'sd32768;
      cfg_r.calo_max  <= 16'sd32767;
      cfg_r.chamb_min <= -16'sd32768;
      cfg_r.chamb_max <= 16'sd32767;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fsf_pkg::cfg_idx_t'(cfg_index))
        fsf_pkg::CFG_SECT_EN:   cfg_r.sect_en   <= cfg_data[0];
        fsf_pkg::CFG_SECT_SEL:  cfg_r.sect_sel  <= cfg_data[2:0];
        fsf_pkg::CFG_CALO_MIN:  cfg_r.calo_min  <= cfg_data;
        fsf_pkg::CFG_CALO_MAX:  cfg_r.calo_max  <= cfg_data;
        fsf_pkg::CFG_CHAMB_MIN: cfg_r.chamb_min <= cfg_data;
        fsf_pkg::CFG_CHAMB_MAX: cfg_r.chamb_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else if (start_go) begin
      size_r <= (in_item.particle_count > EMIT_LIMIT) ? EMIT_LIMIT
                                                      : in_item.particle_count;
    end
  end

  // walker owns the read port while busy, rows otherwise
  assign rd_addr = in_busy ? AW'(rd_idx) : AW'(in_item.particle_index);

  fsf_row_check u_row (
    .clk    (clk),
    .rst_n  (rst_n),
    .row_go (row_go),
    .item   (in_item),
    .cfg    (cfg_r),
    .upd    (upd)
  );

  fsf_flag_mem #(
    .DEPTH (MAX_PARTICLES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (start_go),
    .rd_addr (rd_addr),
    .rd_flag (rd_flag),
    .wr_en   (upd.valid),
    .wr_addr (AW'(upd.idx)),
    .wr_data (rd_flag & ~upd.reject)
  );

  fsf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin_go     (fin_go),
    .event_size (size_r),
    .busy       (in_busy),
    .rd_idx     (rd_idx),
    .tag        (tag)
  );

  assign out_valid          = tag.valid;
  assign out_item.out_index = tag.index;
  assign out_item.pass_flag = rd_flag;
  assign out_item.last_flag = tag.last;

  // every result comes from a walker read issued in the previous cycle
  a_out_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_busy))
    else $error("result without a walker read");

  // no row write-back may land while the walker reads the memory
  a_no_wb_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_busy |-> !upd.valid)
    else $error("row write-back during flag walk");

  // the last result of an event is followed by a gap
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_flag) |=> !out_valid)
    else $error("result right after last flag");

endmodule

// File: tb/tb_top.sv
// self-checking bench for the fiducial sector filter: directed table, then random events
`timescale 1ns / 1ps

module tb_top;

  localparam int FLAG_SLOTS = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 324;
  localparam int NUM_SETTINGS = 6;
  localparam int MAX_PRINTS = 20;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_start = 1'b0;
  logic               in_busy;
  fsf_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  fsf_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  fsf_pkg::cfg_idx_t  cfg_index = fsf_pkg::CFG_SECT_EN;
  logic [15:0]        cfg_data = '0;

  track_fiducial_sector_filter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_start  (in_start),
    .in_busy   (in_busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // filter state as the bench sees it
  logic [63:0]        flag_bits = '1;
  int                 event_len = 0;
  fsf_pkg::cfg_t      cfg_mirror = '{sect_en: 1'b0, sect_sel: 3'd1, calo_min: 16'sh8000,
                                     calo_max: 16'sh7fff, chamb_min: 16'sh8000,
                                     chamb_max: 16'sh7fff};
  fsf_pkg::out_item_t expected_flags[$];

  int n_sent = 0;
  int n_effective = 0;
  int n_checked = 0;
  int n_bad = 0;
  int n_settings = 0;
  int cycles = 0;

  typedef struct {
    fsf_pkg::in_item_t item;
    bit                typed;
    logic [63:0]       flags;
  } dir_row_t;
  dir_row_t dir_tab[$];

  task automatic report_mismatch(string msg);
    n_bad++;
    if (n_bad <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  function automatic int sgn_l(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // sign of a*sqrt(3) + b, kept exact on integers
  function automatic int sgn_root3(longint a, longint b);
    int sa, sb;
    sa = sgn_l(a);
    sb = sgn_l(b);
    if (sa == 0) return sb;
    if (sb == 0 || sa == sb) return sa;
    return (3 * a * a > b * b) ? sa : sb;
  endfunction

  // point lies in the half turn that starts at a ray, ray included
  function automatic bit ray_side(int cr, int dt);
    return (cr > 0) || (cr == 0 && dt > 0);
  endfunction

  function automatic logic [2:0] azimuth_sector(logic signed [15:0] xs, logic signed [15:0] ys);
    longint x, y;
    bit a30, a90, a150;
    x = longint'(xs);
    y = longint'(ys);
    a30  = ray_side(sgn_root3(y, -x), sgn_root3(x, y));
    a90  = ray_side(sgn_l(-x), sgn_l(y));
    a150 = ray_side(sgn_root3(-y, -x), sgn_root3(-x, y));
    if (a30 && !a90) return 3'd2;
    if (a30 && a90 && !a150) return 3'd3;
    if (a30 && a90 && a150) return 3'd4;
    if (!a30 && a90 && a150) return 3'd5;
    if (!a30 && !a90 && a150) return 3'd6;
    return 3'd1;
  endfunction

  task automatic mirror_reg(fsf_pkg::cfg_idx_t idx, logic [15:0] d);
    case (idx)
      fsf_pkg::CFG_SECT_EN:   cfg_mirror.sect_en = d[0];
      fsf_pkg::CFG_SECT_SEL:  cfg_mirror.sect_sel = d[2:0];
      fsf_pkg::CFG_CALO_MIN:  cfg_mirror.calo_min = d;
      fsf_pkg::CFG_CALO_MAX:  cfg_mirror.calo_max = d;
      fsf_pkg::CFG_CHAMB_MIN: cfg_mirror.chamb_min = d;
      fsf_pkg::CFG_CHAMB_MAX: cfg_mirror.chamb_max = d;
      default: ;
    endcase
  endtask

  // update flags for one accepted item, queue the flag reports of a finish
  task automatic filter_step(fsf_pkg::in_item_t it, bit typed, logic [63:0] fl);
    bit rej;
    int i;
    case (it.operation)
      fsf_pkg::OP_START: begin
        flag_bits = '1;
        event_len = (it.particle_count > FLAG_SLOTS) ? FLAG_SLOTS
                                                     : int'(it.particle_count);
        n_effective++;
      end
      fsf_pkg::OP_ROW: begin
        if (it.particle_index < event_len) begin
          rej = 1'b0;
          if (it.detector_id == fsf_pkg::DET_CALO) begin
            if ($signed(it.edge_dist) < $signed(cfg_mirror.calo_min) ||
                $signed(it.edge_dist) > $signed(cfg_mirror.calo_max)) rej = 1'b1;
            if (cfg_mirror.sect_en && it.layer_id == fsf_pkg::LAYER_PRESHOWER &&
                azimuth_sector(it.pos_x, it.pos_y) != cfg_mirror.sect_sel) rej = 1'b1;
          end
          if (it.detector_id == fsf_pkg::DET_CHAMBER) begin
            if ($signed(it.edge_dist) < $signed(cfg_mirror.chamb_min) ||
                $signed(it.edge_dist) > $signed(cfg_mirror.chamb_max)) rej = 1'b1;
          end
          if (rej) flag_bits[it.particle_index] = 1'b0;
          n_effective++;
        end
      end
      fsf_pkg::OP_FINISH: begin
        for (i = 0; i < event_len; i++)
          expected_flags.push_back(fsf_pkg::out_item_t'{
                                     out_index: i[5:0],
                                     pass_flag: typed ? fl[i] : flag_bits[i],
                                     last_flag: (i + 1 == event_len)});
        n_effective++;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    fsf_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_flags.size() == 0) begin
        report_mismatch($sformatf("flag report for index %0d with none pending",
                                  out_item.out_index));
      end else begin
        want = expected_flags.pop_front();
        n_checked++;
        if (out_item.out_index !== want.out_index)
          report_mismatch($sformatf("out_index %0d, want %0d", out_item.out_index,
                                    want.out_index));
        if (out_item.pass_flag !== want.pass_flag)
          report_mismatch($sformatf("pass_flag %b, want %b on index %0d",
                                    out_item.pass_flag, want.pass_flag, want.out_index));
        if (out_item.last_flag !== want.last_flag)
          report_mismatch($sformatf("last_flag %b, want %b on index %0d",
                                    out_item.last_flag, want.last_flag, want.out_index));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d flag reports pending", expected_flags.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic fsf_pkg::in_item_t rand_fill(fsf_pkg::op_t op);
    logic [95:0] r;
    fsf_pkg::in_item_t it;
    r = {$urandom, $urandom, $urandom};
    it = r[$bits(fsf_pkg::in_item_t)-1:0];
    it.operation = op;
    return it;
  endfunction

  function automatic fsf_pkg::in_item_t mk_start(logic [6:0] n);
    fsf_pkg::in_item_t it;
    it = rand_fill(fsf_pkg::OP_START);
    it.particle_count = n;
    return it;
  endfunction

  function automatic fsf_pkg::in_item_t mk_row(logic [5:0] p, logic [7:0] det,
                                               logic [7:0] layer,
                                               logic signed [15:0] x,
                                               logic signed [15:0] y,
                                               logic signed [15:0] e);
    fsf_pkg::in_item_t it;
    it = rand_fill(fsf_pkg::OP_ROW);
    it.particle_index = p;
    it.detector_id = det;
    it.layer_id = layer;
    it.pos_x = x;
    it.pos_y = y;
    it.edge_dist = e;
    return it;
  endfunction

  // hit positions biased toward axes, sector boundaries and extremes
  function automatic logic [31:0] pick_xy();
    logic signed [15:0] x, y;
    int t;
    case ($urandom_range(0, 5))
      0: begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      1: begin
        x = 16'($urandom_range(0, 16) - 8);
        y = 16'($urandom_range(0, 16) - 8);
      end
      2: begin
        x = 16'sd0;
        y = 16'($urandom);
        if ($urandom_range(0, 1)) begin
          x = y;
          y = 16'sd0;
        end
      end
      3: begin
        // just off the 30 and 150 degree lines
        t = $urandom_range(1, 18000);
        x = 16'(t * 97 / 56);
        y = 16'(t);
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1)) y = -y;
      end
      4: begin
        x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        y = $urandom_range(0, 2) == 0 ? 16'sd0 : ($urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff);
      end
      default: begin
        t = $urandom_range(0, 32767);
        x = 16'($urandom_range(0, 1) ? t : -t);
        y = 16'($urandom_range(0, 1) ? t : -t);
      end
    endcase
    return {x, y};
  endfunction

  function automatic logic signed [15:0] pick_edge(bit calo);
    logic signed [15:0] lo, hi;
    lo = calo ? cfg_mirror.calo_min : cfg_mirror.chamb_min;
    hi = calo ? cfg_mirror.calo_max : cfg_mirror.chamb_max;
    case ($urandom_range(0, 5))
      0: return lo;
      1: return lo - 16'sd1;
      2: return hi;
      3: return hi + 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic fsf_pkg::in_item_t rand_row(int sz);
    logic [5:0] p;
    logic [7:0] det, layer;
    logic [31:0] xy;
    int r;
    if (sz > 0 && $urandom_range(0, 9) != 0) p = 6'($urandom_range(0, sz - 1));
    else p = 6'($urandom_range(0, 63));
    r = $urandom_range(0, 19);
    if (r < 8) det = fsf_pkg::DET_CALO;
    else if (r < 15) det = fsf_pkg::DET_CHAMBER;
    else det = 8'($urandom);
    layer = $urandom_range(0, 1) ? fsf_pkg::LAYER_PRESHOWER : 8'($urandom);
    xy = pick_xy();
    return mk_row(p, det, layer, xy[31:16], xy[15:0], pick_edge(det == fsf_pkg::DET_CALO));
  endfunction

  task automatic send(fsf_pkg::in_item_t it, bit typed, logic [63:0] fl);
    in_item <= it;
    in_start <= 1'b1;
    do @(posedge clk); while (in_busy !== 1'b0);
    filter_step(it, typed, fl);
    n_sent++;
  endtask

  task automatic gap(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      in_start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // rows leave no result, so give the row pipeline time to retire
  task automatic drain();
    in_start <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(fsf_pkg::cfg_t c, bit with_spare);
    fsf_pkg::cfg_idx_t idx;
    logic [15:0] d;
    logic [31:0] r;
    idx = fsf_pkg::CFG_SECT_EN;
    repeat (with_spare ? 8 : 6) begin
      r = $urandom;
      case (idx)
        fsf_pkg::CFG_SECT_EN:   d = {r[15:1], c.sect_en};
        fsf_pkg::CFG_SECT_SEL:  d = {r[15:3], c.sect_sel};
        fsf_pkg::CFG_CALO_MIN:  d = c.calo_min;
        fsf_pkg::CFG_CALO_MAX:  d = c.calo_max;
        fsf_pkg::CFG_CHAMB_MIN: d = c.chamb_min;
        fsf_pkg::CFG_CHAMB_MAX: d = c.chamb_max;
        default:                d = r[15:0];
      endcase
      cfg_index <= idx;
      cfg_data <= d;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      mirror_reg(idx, d);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic fsf_pkg::cfg_t pick_settings(int ph);
    fsf_pkg::cfg_t c;
    logic signed [15:0] a, b;
    case (ph)
      0: c = '{sect_en: 1'b0, sect_sel: 3'd1, calo_min: 16'sh8000, calo_max: 16'sh7fff,
               chamb_min: 16'sh8000, chamb_max: 16'sh7fff};
      1: c = '{sect_en: 1'b1, sect_sel: 3'($urandom_range(1, 6)),
               calo_min: -16'($urandom_range(0, 300)), calo_max: 16'($urandom_range(0, 300)),
               chamb_min: -16'($urandom_range(0, 300)), chamb_max: 16'($urandom_range(0, 300))};
      // inverted windows and a sector number no hit can have
      2: c = '{sect_en: 1'b1, sect_sel: $urandom_range(0, 1) ? 3'd0 : 3'd7,
               calo_min: 16'($urandom_range(1, 500)), calo_max: -16'($urandom_range(0, 500)),
               chamb_min: 16'($urandom_range(1, 500)), chamb_max: -16'($urandom_range(0, 500))};
      3: c = '{sect_en: 1'b1, sect_sel: 3'd6, calo_min: 16'sh7fff, calo_max: 16'sh7fff,
               chamb_min: 16'sh8000, chamb_max: 16'sh8000};
      default: begin
        c.sect_en = 1'($urandom);
        c.sect_sel = 3'($urandom);
        a = 16'($urandom);
        b = 16'($urandom);
        c.calo_min = (a < b) ? a : b;
        c.calo_max = (a < b) ? b : a;
        a = 16'($urandom);
        b = 16'($urandom);
        c.chamb_min = (a < b) ? a : b;
        c.chamb_max = (a < b) ? b : a;
      end
    endcase
    return c;
  endfunction

  task automatic run_table();
    foreach (dir_tab[i]) begin
      send(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].flags);
      gap(1'b1);
    end
    dir_tab.delete();
  endtask

  task automatic run_event(bit idle_on);
    int r, cnt, sz, k;
    r = $urandom_range(0, 99);
    if (r < 65) cnt = $urandom_range(1, 10);
    else if (r < 75) cnt = 0;
    else if (r < 87) cnt = $urandom_range(11, 63);
    else if (r < 94) cnt = FLAG_SLOTS;
    else cnt = $urandom_range(65, 127);
    sz = (cnt > FLAG_SLOTS) ? FLAG_SLOTS : cnt;
    send(mk_start(cnt[6:0]), 1'b0, '0);
    gap(idle_on);
    for (k = $urandom_range(0, 14); k > 0; k--) begin
      if ($urandom_range(0, 19) == 0) send(rand_fill(fsf_pkg::OP_NONE), 1'b0, '0);
      else send(rand_row(sz), 1'b0, '0);
      gap(idle_on);
    end
    send(rand_fill(fsf_pkg::OP_FINISH), 1'b0, '0);
    gap(idle_on);
    if ($urandom_range(0, 6) == 0) begin
      send(rand_fill(fsf_pkg::OP_FINISH), 1'b0, '0);
      gap(idle_on);
    end
  endtask

  initial begin
    int ph, target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: row before any start, empty finish, saturated count, ignored code
    dir_tab.push_back('{mk_row(6'd0, fsf_pkg::DET_CALO, 8'd0, 16'sd0, 16'sd0, 16'sh8000),
                        1'b0, '0});
    dir_tab.push_back('{rand_fill(fsf_pkg::OP_FINISH), 1'b1, '0});
    dir_tab.push_back('{mk_start(7'd127), 1'b0, '0});
    dir_tab.push_back('{mk_row(6'd63, fsf_pkg::DET_CHAMBER, 8'hff, 16'sh7fff, 16'sh8000,
                               16'sh8000), 1'b0, '0});
    dir_tab.push_back('{rand_fill(fsf_pkg::OP_FINISH), 1'b1, {64{1'b1}}});
    dir_tab.push_back('{rand_fill(fsf_pkg::OP_NONE), 1'b0, '0});
    run_table();

    drain();
    program_regs('{sect_en: 1'b1, sect_sel: 3'd2, calo_min: -16'sd100, calo_max: 16'sd100,
                   chamb_min: 16'sd0, chamb_max: 16'sd0}, 1'b1);
    dir_tab.push_back('{mk_start(7'd5), 1'b0, '0});
    dir_tab.push_back('{mk_row(6'd0, fsf_pkg::DET_CALO, 8'd0, 16'sd50, 16'sd10, 16'sd101),
                        1'b0, '0});
    dir_tab.push_back('{mk_row(6'd1, fsf_pkg::DET_CALO, 8'd0, 16'sd50, 16'sd10, -16'sd100),
                        1'b0, '0});
    // origin hit sits in sector one, not the chosen one
    dir_tab.push_back('{mk_row(6'd1, fsf_pkg::DET_CALO, fsf_pkg::LAYER_PRESHOWER, 16'sd0,
                               16'sd0, 16'sd0), 1'b0, '0});
    dir_tab.push_back('{mk_row(6'd2, fsf_pkg::DET_CHAMBER, 8'd3, 16'sd0, 16'sd0, 16'sd0),
                        1'b0, '0});
    dir_tab.push_back('{mk_row(6'd2, fsf_pkg::DET_CHAMBER, 8'd3, 16'sd0, 16'sd0, 16'sd1),
                        1'b0, '0});
    dir_tab.push_back('{mk_row(6'd3, fsf_pkg::DET_CALO, fsf_pkg::LAYER_PRESHOWER, 16'sd100,
                               16'sd100, 16'sd0), 1'b0, '0});
    dir_tab.push_back('{mk_row(6'd4, 8'd5, fsf_pkg::LAYER_PRESHOWER, 16'sd0, 16'sd0,
                               16'sh7fff), 1'b0, '0});
    dir_tab.push_back('{mk_row(6'd5, fsf_pkg::DET_CALO, 8'd0, 16'sd0, 16'sd0, 16'sh7fff),
                        1'b0, '0});
    dir_tab.push_back('{rand_fill(fsf_pkg::OP_FINISH), 1'b0, '0});
    dir_tab.push_back('{rand_fill(fsf_pkg::OP_FINISH), 1'b0, '0});
    dir_tab.push_back('{mk_start(7'd0), 1'b0, '0});
    dir_tab.push_back('{rand_fill(fsf_pkg::OP_FINISH), 1'b1, '0});
    dir_tab.push_back('{mk_start(7'd1), 1'b0, '0});
    dir_tab.push_back('{mk_row(6'd0, 8'hff, 8'hff, 16'sh8000, 16'sh8000, 16'sh8000),
                        1'b0, '0});
    dir_tab.push_back('{mk_row(6'd0, fsf_pkg::DET_CHAMBER, 8'd0, 16'sd0, 16'sd0, 16'sd0),
                        1'b0, '0});
    dir_tab.push_back('{rand_fill(fsf_pkg::OP_FINISH), 1'b1, 64'h1});
    run_table();

    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      drain();
      program_regs(pick_settings(ph), ph == 0);
      target = n_effective + RANDOM_ITEMS / NUM_SETTINGS;
      // the last stretch runs with no idle gaps between items
      while (n_effective < target)
        run_event(ph != NUM_SETTINGS - 1 && $urandom_range(0, 4) != 0);
    end

    in_start <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d that change or report flags), checked %0d flag reports",
             n_sent, n_effective, n_checked);
    $display("used %0d register settings, incl. inverted windows and an unmatched sector",
             n_settings);
    if (n_bad == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
